// ===== hdl/stt_pkg.sv =====
// types, codes and reset values of the timer table; its types and codes are shared with its checker
package stt_pkg;

   localparam int SLOT_COUNT_DEF = 16;
   localparam int KEY_BITS_DEF = 16;

   localparam logic [15:0] SLEEP_MIN_RST = 16'd100;
   localparam logic [15:0] SLEEP_MAX_RST = 16'd1000;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_SET,
      OP_STOP
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_STATUS,
      KIND_FIRED,
      KIND_SLEEP
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_NO_FREE,
      STAT_NOT_FOUND
   } status_type;

   typedef enum logic {
      CSR_SLEEP_MIN,
      CSR_SLEEP_MAX
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_RELOAD,
      S_WRITE,
      S_REPLY,
      S_SUMMARY
   } state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] timer_key;
      logic [31:0] countdown_us;
      logic [31:0] interval_us;
      logic [7:0]  queue_id;
      logic [31:0] message;
      logic [63:0] now_us;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [7:0]  fired_queue;
      logic [31:0] fired_message;
      logic [15:0] sleep_us;
      logic        last;
   } rsp_type;

endpackage

// ===== hdl/software_timer_table.sv =====
// timer table: slot store, scan sequencer and one shared 65-bit adder
// tick: scans every slot, plus a reload step per periodic slot reloaded and any result stall
// set and stop: scan for the key, then write (set) and reply; one item at a time, req_stall high meanwhile
// the sequencer does one slot store read and one adder operation per cycle
// reset (synchronous): all slots free, sleep bounds 100 and 1000 us, store contents not cleared
module software_timer_table #(
   parameter int SLOT_COUNT = stt_pkg::SLOT_COUNT_DEF,
   parameter int KEY_BITS   = stt_pkg::KEY_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  stt_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output stt_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_index,
   input  logic [15:0]     csr_wdata
);
   import stt_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   state_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] tgt_ff, tgt_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic free_found_ff, free_found_in;
   logic any_ff, any_in;
   logic [15:0] sleep_ff, sleep_in;
   status_type status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   logic [15:0] sleep_min_ff, sleep_max_ff;

   // slot store
   logic [KEY_BITS-1:0] key_mem [SLOT_COUNT];
   logic [7:0]          queue_mem [SLOT_COUNT];
   logic [31:0]         msg_mem [SLOT_COUNT];
   logic [63:0]         due_mem [SLOT_COUNT];
   logic [31:0]         ival_mem [SLOT_COUNT];
   logic [KEY_BITS-1:0] rd_key_ff;
   logic [7:0]          rd_queue_ff;
   logic [31:0]         rd_msg_ff;
   logic [63:0]         rd_due_ff;
   logic [31:0]         rd_ival_ff;

   logic wr_all, wr_due;
   logic [IDX_W-1:0] wr_addr;

   logic [31:0] key_wide;
   logic [KEY_BITS-1:0] key_value;
   logic [63:0] add_a, add_b;
   logic add_cin;
   logic [64:0] add_sum;
   logic [63:0] sat_value;
   logic out_free, last_slot, match, hit_due, adv, upd;
   logic [63:0] delay;
   logic [15:0] sleep_lo;

   assign key_wide  = {16'd0, req_ff.timer_key};
   assign key_value = key_wide[KEY_BITS-1:0];
   assign add_sum   = {1'b0, add_a} + {1'b0, add_b} + {64'd0, add_cin};
   assign sat_value = add_sum[64] ? '1 : add_sum[63:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_slot = (idx_ff == LAST_IDX);
   assign match     = valid_ff[idx_ff] && (rd_key_ff == key_value);
   assign hit_due   = !add_sum[64] || (add_sum[63:0] == 64'd0);
   assign sleep_lo  = (sleep_ff < sleep_min_ff) ? sleep_min_ff : sleep_ff;
   assign wr_addr   = (state_ff == S_WRITE) ? tgt_ff : idx_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // shared adder operands
   always_comb begin
      add_a   = req_ff.now_us;
      add_b   = 64'd0;
      add_cin = 1'b0;
      unique case (state_ff)
         S_SCAN: begin
            add_a   = rd_due_ff;
            add_b   = ~req_ff.now_us;
            add_cin = 1'b1;
         end
         S_RELOAD: begin
            add_b = {32'd0, rd_ival_ff};
         end
         S_WRITE: begin
            add_b = {32'd0, req_ff.countdown_us};
         end
         S_IDLE, S_REPLY, S_SUMMARY: begin
            add_b = 64'd0;
         end
         default: begin
            add_b = 64'd0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      tgt_in        = tgt_ff;
      free_idx_in   = free_idx_ff;
      free_found_in = free_found_ff;
      any_in        = any_ff;
      sleep_in      = sleep_ff;
      status_in     = status_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      wr_all        = 1'b0;
      wr_due        = 1'b0;
      adv           = 1'b0;
      upd           = 1'b0;
      delay         = 64'd0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               idx_in        = '0;
               free_found_in = 1'b0;
               any_in        = |valid_ff;
               sleep_in      = sleep_max_ff;
               if (req_data.opcode == OP_TICK || req_data.opcode == OP_SET ||
                   req_data.opcode == OP_STOP) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (req_ff.opcode == OP_TICK) begin
               if (!valid_ff[idx_ff]) begin
                  adv = 1'b1;
               end else if (!hit_due) begin
                  delay = add_sum[63:0];
                  upd   = 1'b1;
                  adv   = 1'b1;
               end else if (rd_queue_ff == 8'd0 || out_free) begin
                  if (rd_queue_ff != 8'd0) begin
                     rsp_valid_in         = 1'b1;
                     rsp_in               = '0;
                     rsp_in.kind          = KIND_FIRED;
                     rsp_in.fired_queue   = rd_queue_ff;
                     rsp_in.fired_message = rd_msg_ff;
                  end
                  if (rd_ival_ff != 32'd0) begin
                     state_in = S_RELOAD;
                  end else begin
                     valid_in[idx_ff] = 1'b0;
                     adv              = 1'b1;
                  end
               end
            end else if (match) begin
               tgt_in = idx_ff;
               if (req_ff.opcode == OP_SET) begin
                  state_in = S_WRITE;
               end else begin
                  valid_in[idx_ff] = 1'b0;
                  status_in        = STAT_OK;
                  state_in         = S_REPLY;
               end
            end else begin
               if (!valid_ff[idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if (!last_slot) begin
                  idx_in = idx_ff + IDX_W'(1);
               end else if (req_ff.opcode != OP_SET) begin
                  status_in = STAT_NOT_FOUND;
                  state_in  = S_REPLY;
               end else if (free_found_ff || !valid_ff[idx_ff]) begin
                  tgt_in   = free_found_ff ? free_idx_ff : idx_ff;
                  state_in = S_WRITE;
               end else begin
                  status_in = STAT_NO_FREE;
                  state_in  = S_REPLY;
               end
            end
         end
         S_RELOAD: begin
            wr_due = 1'b1;
            delay  = add_sum[64] ? ~req_ff.now_us : {32'd0, rd_ival_ff};
            upd    = 1'b1;
            adv    = 1'b1;
         end
         S_WRITE: begin
            wr_all           = 1'b1;
            wr_due           = 1'b1;
            valid_in[tgt_ff] = 1'b1;
            status_in        = STAT_OK;
            state_in         = S_REPLY;
         end
         S_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               rsp_in.kind   = KIND_STATUS;
               rsp_in.status = status_ff;
               rsp_in.last   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SUMMARY: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in          = '0;
               rsp_in.kind     = KIND_SLEEP;
               rsp_in.sleep_us = !any_ff ? sleep_max_ff :
                                 (sleep_lo > sleep_max_ff) ? sleep_max_ff : sleep_lo;
               rsp_in.last     = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (upd && delay[63:16] == 48'd0 && delay[15:0] < sleep_ff) begin
         sleep_in = delay[15:0];
      end
      if (adv) begin
         if (last_slot) begin
            state_in = S_SUMMARY;
         end else begin
            idx_in   = idx_ff + IDX_W'(1);
            state_in = S_SCAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      tgt_ff        <= tgt_in;
      free_idx_ff   <= free_idx_in;
      free_found_ff <= free_found_in;
      any_ff        <= any_in;
      sleep_ff      <= sleep_in;
      status_ff     <= status_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sleep_min_ff <= SLEEP_MIN_RST;
         sleep_max_ff <= SLEEP_MAX_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SLEEP_MIN: sleep_min_ff <= csr_wdata;
            CSR_SLEEP_MAX: sleep_max_ff <= csr_wdata;
            default: sleep_max_ff <= sleep_max_ff;
         endcase
      end
   end

   // slot store write and registered read
   always_ff @(posedge clock) begin
      if (wr_all) begin
         key_mem[wr_addr]   <= key_value;
         queue_mem[wr_addr] <= req_ff.queue_id;
         msg_mem[wr_addr]   <= req_ff.message;
         ival_mem[wr_addr]  <= req_ff.interval_us;
      end
      if (wr_due) begin
         due_mem[wr_addr] <= sat_value;
      end
      rd_key_ff   <= key_mem[idx_in];
      rd_queue_ff <= queue_mem[idx_in];
      rd_msg_ff   <= msg_mem[idx_in];
      rd_due_ff   <= due_mem[idx_in];
      rd_ival_ff  <= ival_mem[idx_in];
   end

endmodule

// ===== hdl/stt_checker.sv =====
// port checks for the timer table, bound into every instance of software_timer_table
module stt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input stt_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input stt_pkg::rsp_type rsp_data
);
   import stt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed or dropped");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_data.opcode == OP_TICK || req_data.opcode == OP_SET ||
       req_data.opcode == OP_STOP) |=> req_stall)
      else $error("new word taken while an operation is in progress");

   a_fired_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_FIRED |->
      !rsp_data.last && rsp_data.fired_queue != 8'd0)
      else $error("fired word marked last or without a queue");

   a_final_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_FIRED |-> rsp_data.last)
      else $error("status or summary word not marked last");

endmodule

bind software_timer_table stt_checker u_stt_checker (.*);
